### rtl/core/ppmsd_pkg.sv
// ppmsd_pkg: shared types, phase codes and character constants for the ppm stream decoder
// no dependencies; imported by every module in rtl/core
`default_nettype none

package ppmsd_pkg;

    // default sizes for the top-level parameters
    localparam int DIM_BITS_DEF  = 16;
    localparam int LINE_BITS_DEF = 20;

    // fixed widths of the result fields
    localparam int DIM_OUT_W  = 16;
    localparam int LINE_OUT_W = 20;

    // parser phases
    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_LEADCMT  = 4'd1;
    localparam logic [3:0] PH_EXPECT_P = 4'd2;
    localparam logic [3:0] PH_FMT      = 4'd3;
    localparam logic [3:0] PH_GAPW     = 4'd4;
    localparam logic [3:0] PH_CMTW     = 4'd5;
    localparam logic [3:0] PH_NUMW     = 4'd6;
    localparam logic [3:0] PH_GAPH     = 4'd7;
    localparam logic [3:0] PH_CMTH     = 4'd8;
    localparam logic [3:0] PH_NUMH     = 4'd9;
    localparam logic [3:0] PH_GAPM     = 4'd10;
    localparam logic [3:0] PH_CMTM     = 4'd11;
    localparam logic [3:0] PH_NUMM     = 4'd12;
    localparam logic [3:0] PH_BODY     = 4'd13;
    localparam logic [3:0] PH_HALT     = 4'd14;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_FORMAT     = 3'd0;
    localparam logic [2:0] ERR_MISSING    = 3'd1;
    localparam logic [2:0] ERR_EXP_NUMBER = 3'd2;
    localparam logic [2:0] ERR_EXP_WS     = 3'd3;
    localparam logic [2:0] ERR_MAXVAL     = 3'd4;
    localparam logic [2:0] ERR_EARLY_END  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

    // characters
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [8:0] MAXVAL_CAP   = 9'd256;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
    } ppmsd_in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [31:0]           pixel_word;
        logic                  last_pixel;
        logic [DIM_OUT_W-1:0]  image_width;
        logic [DIM_OUT_W-1:0]  image_height;
        logic [2:0]            error_code;
        logic [LINE_OUT_W-1:0] line_number;
    } ppmsd_out_t;

    function automatic logic is_nl(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

`default_nettype wire

### rtl/core/ppmsd_parser.sv
// ppmsd_parser: parser state registers and the one-byte update logic
// depends on ppmsd_pkg
`default_nettype none

module ppmsd_parser
    import ppmsd_pkg::*;
#(
    parameter int DIM_BITS  = DIM_BITS_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire ppmsd_in_t  item,
    output logic            res_valid,
    output ppmsd_out_t      res
);

    localparam int ACC_W = (DIM_BITS > 9) ? DIM_BITS : 9;
    localparam int V_W   = ACC_W + 4;
    localparam logic [V_W-1:0] DIM_MAX =
        {{(V_W-DIM_BITS){1'b0}}, {DIM_BITS{1'b1}}};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    logic [3:0]           phase_reg,   phase_next;
    logic                 binary_reg,  binary_next;
    logic [ACC_W-1:0]     acc_reg,     acc_next;
    logic                 digit_reg,   digit_next;
    logic [DIM_BITS-1:0]  width_reg,   width_next;
    logic [DIM_BITS-1:0]  height_reg,  height_next;
    logic [DIM_BITS-1:0]  col_reg,     col_next;
    logic [DIM_BITS-1:0]  row_reg,     row_next;
    logic [1:0]           chan_reg,    chan_next;
    logic [7:0]           red_reg,     red_next;
    logic [7:0]           green_reg,   green_next;
    logic [LINE_BITS-1:0] line_reg,    line_next;

    logic [7:0]           c;
    logic [3:0]           d;
    logic [V_W-1:0]       acc_ext;
    logic [V_W-1:0]       v;
    logic [7:0]           body_v;
    logic                 line_inc;
    logic                 err_fire;
    logic [2:0]           err_code;
    logic                 hdr_fire;
    logic                 chan_fire;
    logic [7:0]           chan_val;
    logic                 empty_img;
    logic                 col_wrap;
    logic                 row_end;
    logic                 last_px;
    logic [DIM_BITS-1:0]  col_inc;

    assign c       = item.byte_value;
    assign d       = 4'(c - CH_0);
    assign acc_ext = V_W'(acc_reg);
    assign v       = (acc_ext << 3) + (acc_ext << 1) + V_W'(d);
    assign body_v  = 8'((acc_reg[7:0] << 3) + (acc_reg[7:0] << 1) + 8'(d));
    assign col_inc = col_reg + 1'b1;
    assign col_wrap = ({1'b0, col_reg} + 1'b1) == {1'b0, width_reg};
    assign row_end  = ({1'b0, row_reg} + 1'b1) == {1'b0, height_reg};
    assign last_px  = col_wrap && row_end;

    always_comb
    begin
        phase_next  = phase_reg;
        binary_next = binary_reg;
        acc_next    = acc_reg;
        digit_next  = digit_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        chan_next   = chan_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        line_next   = line_reg;
        line_inc    = 1'b0;
        err_fire    = 1'b0;
        err_code    = ERR_FORMAT;
        hdr_fire    = 1'b0;
        chan_fire   = 1'b0;
        chan_val    = 8'd0;
        empty_img   = (width_reg == '0) || (height_reg == '0);
        res_valid   = 1'b0;
        res         = '0;

        if (item.opcode == OP_EOS)
        begin
            // end of stream: report what is unfinished, then re-arm
            if (phase_reg <= PH_FMT)
            begin
                err_fire = 1'b1;
                err_code = ERR_FORMAT;
            end
            else if (phase_reg == PH_NUMM)
            begin
                err_fire = 1'b1;
                err_code = ERR_EXP_WS;
            end
            else if (phase_reg < PH_NUMM)
            begin
                err_fire = 1'b1;
                err_code = ERR_MISSING;
            end
            else if (phase_reg == PH_BODY)
            begin
                err_fire = 1'b1;
                err_code = ERR_EARLY_END;
            end
            if (err_fire)
            begin
                res_valid       = 1'b1;
                res.kind        = KIND_ERROR;
                res.error_code  = err_code;
                res.line_number = LINE_OUT_W'(line_reg);
            end
            phase_next  = PH_START;
            binary_next = 1'b0;
            acc_next    = '0;
            digit_next  = 1'b0;
            width_next  = '0;
            height_next = '0;
            col_next    = '0;
            row_next    = '0;
            chan_next   = '0;
            red_next    = '0;
            green_next  = '0;
            line_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (c == CH_HASH)
                    begin
                        phase_next = PH_LEADCMT;
                    end
                    else if (c == CH_P)
                    begin
                        phase_next = PH_FMT;
                    end
                    else
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_FORMAT;
                    end
                end
                PH_LEADCMT:
                begin
                    if (is_nl(c))
                    begin
                        line_inc   = 1'b1;
                        phase_next = PH_EXPECT_P;
                    end
                end
                PH_EXPECT_P:
                begin
                    if (c == CH_P)
                    begin
                        phase_next = PH_FMT;
                    end
                    else
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_FORMAT;
                    end
                end
                PH_FMT:
                begin
                    if (c == CH_3 || c == CH_6)
                    begin
                        binary_next = (c == CH_6);
                        phase_next  = PH_GAPW;
                    end
                    else
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_FORMAT;
                    end
                end
                PH_GAPW, PH_GAPH, PH_GAPM:
                begin
                    if (c == CH_HASH)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    else if (is_ws(c))
                    begin
                        line_inc = is_nl(c);
                    end
                    else if (is_digit(c))
                    begin
                        acc_next   = ACC_W'(d);
                        phase_next = phase_reg + 4'd2;
                    end
                    else
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_EXP_NUMBER;
                    end
                end
                PH_CMTW, PH_CMTH, PH_CMTM:
                begin
                    if (is_nl(c))
                    begin
                        line_inc   = 1'b1;
                        phase_next = phase_reg - 4'd1;
                    end
                end
                PH_NUMW, PH_NUMH:
                begin
                    if (is_digit(c))
                    begin
                        if (v > DIM_MAX)
                        begin
                            err_fire = 1'b1;
                            err_code = ERR_OVERFLOW;
                        end
                        else
                        begin
                            acc_next = ACC_W'(v);
                        end
                    end
                    else
                    begin
                        // number ends; this byte is treated as a gap byte
                        if (phase_reg == PH_NUMW)
                        begin
                            width_next = DIM_BITS'(acc_reg);
                            phase_next = PH_GAPH;
                        end
                        else
                        begin
                            height_next = DIM_BITS'(acc_reg);
                            phase_next  = PH_GAPM;
                        end
                        if (c == CH_HASH)
                        begin
                            phase_next = phase_next + 4'd1;
                        end
                        else if (is_ws(c))
                        begin
                            line_inc = is_nl(c);
                        end
                        else
                        begin
                            err_fire = 1'b1;
                            err_code = ERR_EXP_NUMBER;
                        end
                    end
                end
                PH_NUMM:
                begin
                    if (is_digit(c))
                    begin
                        acc_next = (v > V_W'(MAXVAL_CAP)) ? ACC_W'(MAXVAL_CAP)
                                                          : ACC_W'(v);
                    end
                    else if (!is_ws(c))
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_EXP_WS;
                    end
                    else
                    begin
                        line_inc = is_nl(c);
                        if (acc_reg > ACC_W'(8'hFF))
                        begin
                            err_fire = 1'b1;
                            err_code = ERR_MAXVAL;
                        end
                        else
                        begin
                            hdr_fire = 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (binary_reg)
                    begin
                        chan_fire = 1'b1;
                        chan_val  = c;
                    end
                    else if (!digit_reg)
                    begin
                        if (is_ws(c))
                        begin
                            line_inc = is_nl(c);
                        end
                        else if (is_digit(c))
                        begin
                            acc_next   = ACC_W'(d);
                            digit_next = 1'b1;
                        end
                        else
                        begin
                            err_fire = 1'b1;
                            err_code = ERR_EXP_NUMBER;
                        end
                    end
                    else if (is_digit(c))
                    begin
                        acc_next = ACC_W'(body_v);
                    end
                    else if (!is_ws(c))
                    begin
                        err_fire = 1'b1;
                        err_code = ERR_EXP_NUMBER;
                    end
                    else
                    begin
                        // separator closes the sample, not counted as a line
                        digit_next = 1'b0;
                        chan_fire  = 1'b1;
                        chan_val   = acc_reg[7:0];
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (line_inc && line_reg != LINE_MAX)
            begin
                line_next = line_reg + 1'b1;
            end

            if (err_fire)
            begin
                res_valid       = 1'b1;
                res.kind        = KIND_ERROR;
                res.error_code  = err_code;
                res.line_number = LINE_OUT_W'(line_next);
                phase_next      = PH_HALT;
            end
            else if (hdr_fire)
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_HEADER;
                res.last_pixel   = empty_img;
                res.image_width  = DIM_OUT_W'(width_reg);
                res.image_height = DIM_OUT_W'(height_reg);
                col_next         = '0;
                row_next         = '0;
                chan_next        = '0;
                digit_next       = 1'b0;
                acc_next         = '0;
                phase_next       = empty_img ? PH_HALT : PH_BODY;
            end
            else if (chan_fire)
            begin
                if (chan_reg == 2'd0)
                begin
                    red_next  = chan_val;
                    chan_next = 2'd1;
                end
                else if (chan_reg == 2'd1)
                begin
                    green_next = chan_val;
                    chan_next  = 2'd2;
                end
                else
                begin
                    chan_next      = 2'd0;
                    res_valid      = 1'b1;
                    res.kind       = KIND_PIXEL;
                    res.pixel_word = {ALPHA_OPAQUE, chan_val, green_reg, red_reg};
                    res.last_pixel = last_px;
                    if (col_wrap)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    if (last_px)
                    begin
                        phase_next = PH_HALT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            binary_reg <= 1'b0;
            acc_reg    <= '0;
            digit_reg  <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            chan_reg   <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            line_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            binary_reg <= binary_next;
            acc_reg    <= acc_next;
            digit_reg  <= digit_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            chan_reg   <= chan_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            line_reg   <= line_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ppmsd_out_stage.sv
// ppmsd_out_stage: result register and the input-side ready
// depends on ppmsd_pkg
`default_nettype none

module ppmsd_out_stage
    import ppmsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    output logic            step,
    input  wire logic       res_valid,
    input  wire ppmsd_out_t res,
    output logic            result_valid,
    input  wire logic       result_ready,
    output ppmsd_out_t      result
);

    logic       valid_reg;
    ppmsd_out_t data_reg;

    // a new word enters whenever the held result leaves or none is held
    assign item_ready   = !valid_reg || result_ready;
    assign step         = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= res_valid;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ppm_stream_decoder.sv
// ppm_stream_decoder: P3/P6 image decoder, one file byte per word,
// one word accepted per clock when the result side keeps up; the parser update is a single
// registered step and a result appears on result_valid the cycle after its word is accepted
// reset (rst_n low, asynchronous) returns the parser to the start of a header with the line
// count cleared and drops any held result; an end-of-stream word re-arms the same way
// depends on ppmsd_pkg, ppmsd_parser, ppmsd_out_stage
`default_nettype none

module ppm_stream_decoder
    import ppmsd_pkg::*;
#(
    parameter int DIM_BITS  = DIM_BITS_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire ppmsd_in_t  item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output ppmsd_out_t      result
);

    // step: the input word is taken this edge and the parser state advances
    logic       step;
    logic       res_valid;
    ppmsd_out_t res;

    // header fields, comments, sample digits and the pixel assembly all live
    // in the parser; it only moves on an accepted word
    ppmsd_parser #(
        .DIM_BITS  (DIM_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // the result register decouples the two sides so a byte can be taken
    // in the same cycle the previous result is handed out
    ppmsd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .step         (step),
        .res_valid    (res_valid),
        .res          (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ready only drops while a result is held back by the consumer
    a_ready_only_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid && !result_ready)
    ) else $error("input stalled without a pending result");

    // a word that produces a result shows it, unchanged, on the next cycle
    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> (result_valid && result == $past(res))
    ) else $error("result lost or altered in the output register");

    // every pixel is opaque
    a_pixel_alpha: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_PIXEL)
            |-> (result.pixel_word[31:24] == ALPHA_OPAQUE)
    ) else $error("pixel word without full alpha");

endmodule

`default_nettype wire

### test/ppm_stream_decoder_tb.sv
// ppm_stream_decoder_tb: self-checking bench for the P3/P6 stream decoder, random files plus
// a few directed ones, with a word-level decoder model inside a scoreboard class
// depends on ppmsd_pkg and ppm_stream_decoder

module ppm_stream_decoder_tb;
    import ppmsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM_LIMIT   = (1 << DIM_BITS_DEF) - 1;
    localparam int unsigned LINE_LIMIT  = (1 << LINE_BITS_DEF) - 1;
    localparam int unsigned WORD_TARGET = 1675;   // directed words plus about 1650 random
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_WAIT  = 8;      // block answers in the cycle after acceptance

    // model of the decoder plus the queue of decoded words still to arrive
    class decoder_scoreboard;
        ppmsd_out_t  decoded_q[$];
        int unsigned mismatch_count;

        // parser state
        logic [3:0]  phase;
        bit          binary;
        bit          digit_seen;
        int unsigned accum;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned col;
        int unsigned row;
        int unsigned chan;
        logic [7:0]  red_hold;
        logic [7:0]  green_hold;
        int unsigned line_cnt;

        function new();
            mismatch_count = 0;
            rearm();
        endfunction

        function void rearm();
            phase      = PH_START;
            binary     = 1'b0;
            digit_seen = 1'b0;
            accum      = 0;
            width_reg  = 0;
            height_reg = 0;
            col        = 0;
            row        = 0;
            chan       = 0;
            red_hold   = '0;
            green_hold = '0;
            line_cnt   = 0;
        endfunction

        function bit line_break(logic [7:0] c);
            return c == CH_LF || c == CH_CR;
        endfunction

        function bit blank(logic [7:0] c);
            return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function void bump_line();
            if (line_cnt < LINE_LIMIT)
                line_cnt++;
        endfunction

        function bit raise(output ppmsd_out_t r, input logic [2:0] code);
            r = '0;
            r.kind        = KIND_ERROR;
            r.error_code  = code;
            r.line_number = LINE_OUT_W'(line_cnt);
            phase = PH_HALT;
            return 1'b1;
        endfunction

        // between header fields: comment, blank or first digit
        function bit gap_byte(logic [7:0] c, logic [3:0] gap, output ppmsd_out_t r);
            r = '0;
            if (c == CH_HASH)
                phase = gap + 4'd1;
            else if (blank(c))
            begin
                if (line_break(c))
                    bump_line();
            end
            else if (numeral(c))
            begin
                accum = c - CH_0;
                phase = gap + 4'd2;
            end
            else
                return raise(r, ERR_EXP_NUMBER);
            return 1'b0;
        endfunction

        function bit channel_done(logic [7:0] v, output ppmsd_out_t r);
            bit last;
            r = '0;
            if (chan == 0)
            begin
                red_hold = v;
                chan = 1;
                return 1'b0;
            end
            if (chan == 1)
            begin
                green_hold = v;
                chan = 2;
                return 1'b0;
            end
            chan = 0;
            last = (col + 1 == width_reg) && (row + 1 == height_reg);
            r.kind       = KIND_PIXEL;
            r.pixel_word = {ALPHA_OPAQUE, v, green_hold, red_hold};
            r.last_pixel = last;
            col++;
            if (col >= width_reg)
            begin
                col = 0;
                row++;
            end
            if (last)
                phase = PH_HALT;
            return 1'b1;
        endfunction

        function bit body_byte(logic [7:0] c, output ppmsd_out_t r);
            r = '0;
            if (binary)
                return channel_done(c, r);
            if (!digit_seen)
            begin
                if (blank(c))
                begin
                    if (line_break(c))
                        bump_line();
                    return 1'b0;
                end
                if (!numeral(c))
                    return raise(r, ERR_EXP_NUMBER);
                accum = c - CH_0;
                digit_seen = 1'b1;
                return 1'b0;
            end
            if (numeral(c))
            begin
                accum = (accum * 10 + (c - CH_0)) & 8'hFF;
                return 1'b0;
            end
            if (!blank(c))
                return raise(r, ERR_EXP_NUMBER);
            // the separator after a sample is not counted as a line break
            digit_seen = 1'b0;
            return channel_done(accum[7:0], r);
        endfunction

        function bit header_done(output ppmsd_out_t r);
            bit empty;
            empty = (width_reg == 0) || (height_reg == 0);
            r = '0;
            r.kind         = KIND_HEADER;
            r.last_pixel   = empty;
            r.image_width  = DIM_OUT_W'(width_reg);
            r.image_height = DIM_OUT_W'(height_reg);
            col        = 0;
            row        = 0;
            chan       = 0;
            digit_seen = 1'b0;
            accum      = 0;
            phase = empty ? PH_HALT : PH_BODY;
            return 1'b1;
        endfunction

        function bit decode_word(ppmsd_in_t w, output ppmsd_out_t r);
            logic [7:0]  c;
            int unsigned v;
            bit          hit;
            c = w.byte_value;
            r = '0;
            if (w.opcode == OP_EOS)
            begin
                hit = 1'b1;
                if (phase <= PH_FMT)
                    void'(raise(r, ERR_FORMAT));
                else if (phase == PH_NUMM)
                    void'(raise(r, ERR_EXP_WS));
                else if (phase < PH_NUMM)
                    void'(raise(r, ERR_MISSING));
                else if (phase == PH_BODY)
                    void'(raise(r, ERR_EARLY_END));
                else
                    hit = 1'b0;
                rearm();
                return hit;
            end
            case (phase)
                PH_START:
                begin
                    if (c == CH_HASH)
                        phase = PH_LEADCMT;
                    else if (c == CH_P)
                        phase = PH_FMT;
                    else
                        return raise(r, ERR_FORMAT);
                    return 1'b0;
                end
                PH_LEADCMT:
                begin
                    if (line_break(c))
                    begin
                        bump_line();
                        phase = PH_EXPECT_P;
                    end
                    return 1'b0;
                end
                PH_EXPECT_P:
                begin
                    if (c != CH_P)
                        return raise(r, ERR_FORMAT);
                    phase = PH_FMT;
                    return 1'b0;
                end
                PH_FMT:
                begin
                    if (c == CH_3)
                        binary = 1'b0;
                    else if (c == CH_6)
                        binary = 1'b1;
                    else
                        return raise(r, ERR_FORMAT);
                    phase = PH_GAPW;
                    return 1'b0;
                end
                PH_GAPW, PH_GAPH, PH_GAPM:
                    return gap_byte(c, phase, r);
                PH_CMTW, PH_CMTH, PH_CMTM:
                begin
                    if (line_break(c))
                    begin
                        bump_line();
                        phase = phase - 4'd1;
                    end
                    return 1'b0;
                end
                PH_NUMW, PH_NUMH:
                begin
                    if (numeral(c))
                    begin
                        v = accum * 10 + (c - CH_0);
                        if (v > DIM_LIMIT)
                            return raise(r, ERR_OVERFLOW);
                        accum = v;
                        return 1'b0;
                    end
                    if (phase == PH_NUMW)
                    begin
                        width_reg = accum;
                        phase = PH_GAPH;
                    end
                    else
                    begin
                        height_reg = accum;
                        phase = PH_GAPM;
                    end
                    return gap_byte(c, phase, r);
                end
                PH_NUMM:
                begin
                    if (numeral(c))
                    begin
                        v = accum * 10 + (c - CH_0);
                        accum = (v > MAXVAL_CAP) ? MAXVAL_CAP : v;
                        return 1'b0;
                    end
                    if (!blank(c))
                        return raise(r, ERR_EXP_WS);
                    if (line_break(c))
                        bump_line();
                    if (accum > 255)
                        return raise(r, ERR_MAXVAL);
                    return header_done(r);
                end
                PH_BODY:
                    return body_byte(c, r);
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_word(ppmsd_in_t w);
            ppmsd_out_t r;
            if (decode_word(w, r))
                decoded_q.push_back(r);
        endfunction

        function void check_result(ppmsd_out_t got);
            ppmsd_out_t want;
            if (decoded_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: kind %0d pixel %h err %0d",
                             got.kind, got.pixel_word, got.error_code);
                return;
            end
            want = decoded_q.pop_front();
            if (got.kind != want.kind || got.pixel_word != want.pixel_word ||
                got.last_pixel != want.last_pixel || got.image_width != want.image_width ||
                got.image_height != want.image_height || got.error_code != want.error_code ||
                got.line_number != want.line_number)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("expected kind %0d pix %h last %0d w %0d h %0d err %0d line %0d",
                             want.kind, want.pixel_word, want.last_pixel, want.image_width,
                             want.image_height, want.error_code, want.line_number);
                    $display("actual   kind %0d pix %h last %0d w %0d h %0d err %0d line %0d",
                             got.kind, got.pixel_word, got.last_pixel, got.image_width,
                             got.image_height, got.error_code, got.line_number);
                end
            end
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    ppmsd_in_t  item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    ppmsd_out_t result;

    decoder_scoreboard sb = new();

    // bytes of the file being built, sent in order and closed by an end-of-stream word
    logic [7:0]  file_q[$];
    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    // receiver stall state
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    logic [15:0] stall_mask = 16'hFFFF;

    ppm_stream_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ppm_stream_decoder_tb failed");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge; result checked before the word
    // accepted in the same cycle is modeled, so a stray result is never hidden
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (item_valid && item_ready)
                sb.note_word(item);
        end
    end

    // receiver: spans of always ready, coin flips, a rotating mask, or rare stalls
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_mask = 16'($urandom) | 16'h0001;
            stall_span = $urandom_range(16, 96);
        end
        stall_span--;
        stall_mask = {stall_mask[14:0], stall_mask[15]};
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= stall_mask[0];
            default: result_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // one word per call; bursts of back-to-back words separated by random gaps
    task automatic send_word(input logic op, input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_valid      <= 1'b1;
        item.opcode     <= op;
        item.byte_value <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
        @(negedge clk);
    endtask

    // file bytes, then end of stream with a random don't-care byte
    task automatic send_file();
        foreach (file_q[i])
            send_word(OP_BYTE, file_q[i]);
        send_word(OP_EOS, 8'($urandom));
        file_q.delete();
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            file_q.push_back(s[i]);
    endtask

    task automatic push_number(input int unsigned n);
        if ($urandom_range(0, 7) == 0)
            file_q.push_back(CH_0);
        push_text($sformatf("%0d", n));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return CH_CR;
            default: return CH_SP;
        endcase
    endfunction

    // '#' comment running to a line break, with no break inside
    task automatic push_comment();
        int unsigned n;
        logic [7:0]  b;
        file_q.push_back(CH_HASH);
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            b = 8'($urandom);
            file_q.push_back((b == CH_LF || b == CH_CR) ? 8'h7E : b);
        end
        file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
    endtask

    // separator between header fields, sometimes carrying a comment
    task automatic push_gap();
        int unsigned n;
        n = $urandom_range(1, 3);
        repeat (n)
            file_q.push_back(pick_blank());
        if ($urandom_range(0, 5) == 0)
            push_comment();
    endtask

    function automatic int unsigned pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 65535;
            1:       return 65534;
            2:       return 65536;
            3:       return 99999;
            default: return 100000;
        endcase
    endfunction

    // mostly well-formed small images; some noise, truncation and corruption
    task automatic build_file();
        int unsigned w;
        int unsigned h;
        int unsigned maxval;
        int unsigned pick;
        int unsigned cut;
        bit          raw;
        logic [7:0]  fmt;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            repeat ($urandom_range(1, 8))
                file_q.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 4) == 0)
            push_comment();
        file_q.push_back(CH_P);
        raw = 1'($urandom_range(0, 1));
        fmt = raw ? CH_6 : CH_3;
        if ($urandom_range(0, 19) == 0)
            fmt = 8'($urandom);
        file_q.push_back(fmt);

        // sizes: huge ones only alongside a zero so the body stays empty
        if ($urandom_range(0, 99) < 6)
        begin
            if ($urandom_range(0, 1))
            begin
                w = pick_extreme();
                h = 0;
            end
            else
            begin
                w = 0;
                h = pick_extreme();
            end
        end
        else
        begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        end
        push_gap();
        push_number(w);
        push_gap();
        push_number(h);
        push_gap();

        pick = $urandom_range(0, 99);
        if (pick < 80)
            maxval = $urandom_range(1, 255);
        else if (pick < 88)
            maxval = 255;
        else if (pick < 94)
            maxval = $urandom_range(256, 99999);
        else
            maxval = 0;
        push_number(maxval);
        // exactly one blank closes the header, now and then a bad byte instead
        file_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : pick_blank());

        repeat (w * h * 3)
        begin
            if (raw)
                file_q.push_back(8'($urandom));
            else
            begin
                push_number($urandom_range(0, 999));
                file_q.push_back(pick_blank());
                if ($urandom_range(0, 3) == 0)
                    file_q.push_back(pick_blank());
            end
        end

        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            cut = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > cut)
                file_q.delete(file_q.size() - 1);
        end
        else if (pick < 22)
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        else if (pick < 27)
        begin
            repeat ($urandom_range(1, 3))
                file_q.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // end of stream straight after reset
        send_file();
        // empty image: zero width gives a header flagged last and no body
        push_text("P6 0 5 9\n");
        send_file();
        // width digits overflow the size field
        push_text("P6 99999");
        send_file();
        // leading comment closed by CR, then a byte other than 'P'
        push_text("#x");
        file_q.push_back(CH_CR);
        push_text("Z");
        send_file();

        while (words_sent < WORD_TARGET)
        begin
            build_file();
            send_file();
        end
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("ppm_stream_decoder_tb passed");
        else
            $display("ppm_stream_decoder_tb failed");
        $finish;
    end

endmodule
